// ===== hdl/rtp_pkg.sv =====
// Shared types, codes and constants of the RTP header generator.
package rtp_pkg;

    localparam int SESSIONS_DEF = 16;
    localparam int HEADER_BYTES = 12;
    localparam logic [1:0] RTP_VERSION = 2'd2;

    // Request codes
    localparam logic [1:0] REQ_OPEN  = 2'd0;
    localparam logic [1:0] REQ_CLOSE = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;
    localparam logic [1:0] REQ_BUILD = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SESS = 3'd1;
    localparam logic [2:0] ST_OPEN     = 3'd2;
    localparam logic [2:0] ST_ROOM     = 3'd3;
    localparam logic [2:0] ST_INACTIVE = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // One session record as held in the record memory
    typedef struct packed {
        logic [6:0]  ptype;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] src;
        logic        marker;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

// ===== hdl/rtp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/rtp_header_generator.sv =====
// RTP header generator: session table in RAM and header byte streamer.
//
// Use: present a request on the input ports and raise start; it is taken
// at a clock edge where start is high and busy is low. busy stays high
// until the request has finished its work in the session table.
// Results leave on the output ports, one per cycle, each marked by strobe
// for exactly one cycle; the receiver must take every transfer as it comes.
// Open, close, set-increment and failed or empty builds give one result,
// registered from the execute state. A good build gives twelve header
// bytes on consecutive cycles from the stream state, last set on byte
// eleven. A new request can be taken at the edge that ends the first
// cycle with busy low; the time a request holds the block is set by the
// registered read of the session memories, the read-modify-write in the
// execute state and the one-byte-per-cycle header stream.
// Reset clears every active flag and every stored increment at once (flop
// valid bits, no clearing pass); other session fields are written on open.
// busy covers the whole read-modify-write, so no two accesses to one
// session overlap.
module rtp_header_generator #(
    parameter int SESSIONS = rtp_pkg::SESSIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  session,
    input  logic [6:0]  media_type,
    input  logic [15:0] initial_sequence,
    input  logic [31:0] initial_timestamp,
    input  logic [31:0] source_id,
    input  logic [31:0] timestamp_increment,
    input  logic [15:0] body_length,
    input  logic [15:0] buffer_size,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [7:0]  header_byte,
    output logic [3:0]  byte_index,
    output logic [16:0] packet_length,
    output logic        session_active,
    output logic        last
);

    import rtp_pkg::*;

    localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int HDR_W = HEADER_BYTES * 8;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SESSIONS-1:0] active_reg, active_next;
    logic [SESSIONS-1:0] inc_ok_reg, inc_ok_next;

    // Latched request
    logic        bad_reg;
    logic [1:0]  req_reg;
    logic [7:0]  sess_reg;
    logic [6:0]  ptype_reg;
    logic [15:0] iseq_reg;
    logic [31:0] its_reg;
    logic [31:0] src_reg;
    logic [31:0] incin_reg;
    logic [15:0] plen_reg;
    logic [15:0] bsize_reg;

    logic [HDR_W-1:0] hdr_reg, hdr_next;
    logic [3:0]       cnt_reg, cnt_next;

    logic        strobe_reg, strobe_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  hbyte_reg, hbyte_next;
    logic [3:0]  bidx_reg, bidx_next;
    logic [16:0] plen_out_reg, plen_out_next;
    logic        act_out_reg, act_out_next;
    logic        last_reg, last_next;

    logic             accept;
    logic [IDX_W-1:0] idx;
    logic             rec_we;
    rec_t             rec_wdata;
    rec_t             rec_rd;
    logic [REC_W-1:0] rec_rdata;
    logic             inc_we;
    logic [31:0]      inc_rdata;
    logic [31:0]      inc_val;
    logic             act_cur;
    logic [16:0]      total_len;
    logic             room_bad;
    logic [15:0]      seq_new;
    logic [31:0]      ts_new;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign idx    = sess_reg[IDX_W-1:0];
    assign rec_rd = rec_t'(rec_rdata);

    // Session record and increment memories, read at the accepting edge
    rtp_ram #(.WIDTH(REC_W), .DEPTH(SESSIONS)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (idx),
        .wdata (rec_wdata),
        .raddr (session[IDX_W-1:0]),
        .rdata (rec_rdata)
    );

    rtp_ram #(.WIDTH(32), .DEPTH(SESSIONS)) u_inc_ram (
        .clk   (clk),
        .we    (inc_we),
        .waddr (idx),
        .wdata (incin_reg),
        .raddr (session[IDX_W-1:0]),
        .rdata (inc_rdata)
    );

    // Derive the modified session values
    assign act_cur   = active_reg[idx];
    assign inc_val   = inc_ok_reg[idx] ? inc_rdata : 32'd0;
    assign total_len = 17'(HEADER_BYTES) + {1'b0, plen_reg};
    assign room_bad  = ({1'b0, bsize_reg} < total_len);
    assign seq_new   = rec_rd.seq + 16'd1;
    assign ts_new    = rec_rd.ts + inc_val;

    // Decide the outcome, write back and stream
    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        inc_ok_next   = inc_ok_reg;
        hdr_next      = hdr_reg;
        cnt_next      = cnt_reg;
        strobe_next   = 1'b0;
        status_next   = ST_OK;
        hbyte_next    = 8'd0;
        bidx_next     = 4'd0;
        plen_out_next = 17'd0;
        act_out_next  = 1'b0;
        last_next     = 1'b1;
        rec_we        = 1'b0;
        rec_wdata     = rec_rd;
        inc_we        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                strobe_next = 1'b1;
                state_next  = S_IDLE;
                if (bad_reg)
                begin
                    status_next = ST_BAD_SESS;
                end
                else
                begin
                    unique case (req_reg)
                        REQ_OPEN:
                        begin
                            act_out_next = 1'b1;
                            if (act_cur)
                            begin
                                status_next = ST_OPEN;
                            end
                            else
                            begin
                                rec_we           = 1'b1;
                                rec_wdata.ptype  = ptype_reg;
                                rec_wdata.seq    = iseq_reg;
                                rec_wdata.ts     = its_reg;
                                rec_wdata.src    = src_reg;
                                rec_wdata.marker = 1'b1;
                                active_next[idx] = 1'b1;
                            end
                        end
                        REQ_CLOSE:
                        begin
                            active_next[idx] = 1'b0;
                        end
                        REQ_SET:
                        begin
                            inc_we           = 1'b1;
                            inc_ok_next[idx] = 1'b1;
                            act_out_next     = act_cur;
                        end
                        REQ_BUILD:
                        begin
                            if (room_bad)
                            begin
                                status_next  = ST_ROOM;
                                act_out_next = act_cur;
                            end
                            else if (!act_cur)
                            begin
                                status_next = ST_INACTIVE;
                            end
                            else
                            begin
                                rec_we           = 1'b1;
                                rec_wdata.seq    = seq_new;
                                rec_wdata.ts     = ts_new;
                                rec_wdata.marker = 1'b0;
                                act_out_next     = 1'b1;
                                if (plen_reg == 16'd0)
                                begin
                                    status_next = ST_EMPTY;
                                end
                                else
                                begin
                                    // Hold the header and stream it from the next cycle
                                    strobe_next = 1'b0;
                                    state_next  = S_STREAM;
                                    cnt_next    = 4'd0;
                                    hdr_next    = {RTP_VERSION, 6'd0, rec_rd.marker,
                                                   rec_rd.ptype, seq_new, ts_new,
                                                   rec_rd.src};
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_STREAM:
            begin
                // Emit the top byte and advance
                strobe_next   = 1'b1;
                hbyte_next    = hdr_reg[HDR_W-1 -: 8];
                bidx_next     = cnt_reg;
                plen_out_next = total_len;
                act_out_next  = 1'b1;
                last_next     = (cnt_reg == 4'(HEADER_BYTES - 1));
                hdr_next      = hdr_reg << 8;
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'(HEADER_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            inc_ok_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            inc_ok_reg <= inc_ok_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bad_reg   <= ({1'b0, session} >= 9'(SESSIONS));
            req_reg   <= req_type;
            sess_reg  <= session;
            ptype_reg <= media_type;
            iseq_reg  <= initial_sequence;
            its_reg   <= initial_timestamp;
            src_reg   <= source_id;
            incin_reg <= timestamp_increment;
            plen_reg  <= body_length;
            bsize_reg <= buffer_size;
        end
        hdr_reg      <= hdr_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        hbyte_reg    <= hbyte_next;
        bidx_reg     <= bidx_next;
        plen_out_reg <= plen_out_next;
        act_out_reg  <= act_out_next;
        last_reg     <= last_next;
    end

    assign strobe         = strobe_reg;
    assign status         = status_reg;
    assign header_byte    = hbyte_reg;
    assign byte_index     = bidx_reg;
    assign packet_length  = plen_out_reg;
    assign session_active = act_out_reg;
    assign last           = last_reg;

endmodule

// ===== hdl/rtp_chk.sv =====
// Port-level checker for the RTP header generator, bound to the top level.
module rtp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [2:0]  status,
    input logic [7:0]  header_byte,
    input logic [3:0]  byte_index,
    input logic [16:0] packet_length,
    input logic        last
);

    import rtp_pkg::*;

    // A taken request occupies the block for at least the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but busy not raised");

    // A result with an error status is always a lone final transfer with zero length and byte
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != ST_OK |-> last && packet_length == 17'd0 && header_byte == 8'd0)
        else $error("error result not a lone final transfer");

    // Header bytes arrive back to back with rising index
    a_stream_next: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && byte_index == $past(byte_index) + 4'd1)
        else $error("header stream broken");

    // Drop no header: the first byte carries version two
    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == ST_OK && packet_length != 17'd0 && byte_index == 4'd0
        |-> header_byte == {RTP_VERSION, 6'd0})
        else $error("first header byte wrong");

endmodule

bind rtp_header_generator rtp_chk u_rtp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .strobe        (strobe),
    .status        (status),
    .header_byte   (header_byte),
    .byte_index    (byte_index),
    .packet_length (packet_length),
    .last          (last)
);
